// ----- sv/csc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Centred stick conditioner package
// Shared widths, constants, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package csc_pkg;

   // Defaults for the top-level parameters
   localparam int HISTORY_DEPTH_DEFAULT = 9;
   localparam int SAMPLE_BITS_DEFAULT   = 10;

   // Fixed field widths
   localparam int LEVEL_W     = 10;
   localparam int MARGIN_W    = 8;
   localparam int POS_W       = 10;
   localparam int DIR_W       = 2;
   localparam int STEP_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int SCALE_W     = 9;   // bits of the 500 scale factor

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_LEVEL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_MARGIN = 2'd2;

   // Register reset values
   localparam logic [LEVEL_W-1:0]  LOW_LEVEL_RESET   = 10'd0;
   localparam logic [LEVEL_W-1:0]  HIGH_LEVEL_RESET  = 10'd1023;
   localparam logic [MARGIN_W-1:0] DEAD_MARGIN_RESET = 8'd8;
   localparam int                  CENTRE_RESET      = 512;

   // Position scale
   localparam logic [POS_W-1:0] POS_ZERO   = 10'd0;
   localparam logic [POS_W-1:0] POS_CENTRE = 10'd500;
   localparam logic [POS_W-1:0] POS_FULL   = 10'd1000;

   // Divide by 50 as multiply by 1311 and shift by 16, exact for 0..500
   localparam int                     STEP_RECIP_W = 11;
   localparam logic [STEP_RECIP_W-1:0] STEP_RECIP  = 11'd1311;
   localparam int                     STEP_SHIFT   = 16;

   // Direction codes
   localparam logic [DIR_W-1:0] DIR_CENTRED  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_POSITIVE = 2'd1;
   localparam logic [DIR_W-1:0] DIR_NEGATIVE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEDIAN,
      ST_SETUP,
      ST_DIVIDE,
      ST_POSITION,
      ST_LOAD
   } csc_state_type;

   typedef struct packed {
      logic capture;
      logic med_step;
      logic setup;
      logic div_step;
      logic position;
      logic load_out;
   } csc_cmd_type;

   typedef struct packed {
      logic cal_req;
      logic med_done;
      logic bypass;
      logic div_done;
   } csc_status_type;

endpackage
`default_nettype wire

// ----- sv/centred_stick_conditioner_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each beat carries one raw stick sample and an action; one result beat comes
// back per item, in order. An item is taken, then passes through the median
// rank scan if it calibrates (action 1, or the first item after reset), map
// setup, the one-bit-per-cycle restoring divider and the position step when
// the sample lies outside the dead band with a positive span, and the load
// of the output register, which waits until that register is free. The next
// item is taken in the cycle after the load, while the previous result may
// still wait on rsp_ready.
// ----------------------------------------------------------------------------
// Centred stick conditioner
// Median-of-history midpoint calibration, dead band and span mapping of a
// raw stick sample to a 0..1000 position with a coarse signed step.
// ----------------------------------------------------------------------------
module centred_stick_conditioner_top #(
   parameter int HISTORY_DEPTH = csc_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS   = csc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [csc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [SAMPLE_BITS-1:0]          req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [csc_pkg::POS_W-1:0]       rsp_position,
   output logic [csc_pkg::DIR_W-1:0]       rsp_direction,
   output logic [csc_pkg::STEP_W-1:0]      rsp_step,
   output logic [csc_pkg::LEVEL_W-1:0]     rsp_centre_now
);

   csc_pkg::csc_cmd_type    cmd;
   csc_pkg::csc_status_type status;

   csc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   csc_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_action     (req_action),
      .req_sample     (req_sample),
      .cmd            (cmd),
      .status         (status),
      .rsp_position   (rsp_position),
      .rsp_direction  (rsp_direction),
      .rsp_step       (rsp_step),
      .rsp_centre_now (rsp_centre_now)
   );

endmodule
`default_nettype wire

// ----- sv/csc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Centred stick conditioner controller
// Sequences capture, median scan, map setup, divide, position and result
// load, and owns both handshakes.
// ----------------------------------------------------------------------------
module csc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  csc_pkg::csc_status_type status,
   output csc_pkg::csc_cmd_type    cmd
);

   csc_pkg::csc_state_type state_ff;
   csc_pkg::csc_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         csc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.cal_req ? csc_pkg::ST_MEDIAN : csc_pkg::ST_SETUP;
            end
         end
         csc_pkg::ST_MEDIAN: begin
            cmd.med_step = 1'b1;
            if (status.med_done) begin
               state_in = csc_pkg::ST_SETUP;
            end
         end
         csc_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.bypass ? csc_pkg::ST_LOAD : csc_pkg::ST_DIVIDE;
         end
         csc_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = csc_pkg::ST_POSITION;
            end
         end
         csc_pkg::ST_POSITION: begin
            cmd.position = 1'b1;
            state_in     = csc_pkg::ST_LOAD;
         end
         csc_pkg::ST_LOAD: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = csc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while an item is in flight");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result valid without a load");

   a_divide_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csc_pkg::ST_DIVIDE && status.div_done) |=>
      state_ff == csc_pkg::ST_POSITION)
      else $error("divide did not hand over to position");
`endif

endmodule
`default_nettype wire

// ----- sv/csc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Centred stick conditioner datapath
// Settings registers, calibration history with rank-scan median, span setup,
// restoring divider and result registers.
// ----------------------------------------------------------------------------
module csc_datapath #(
   parameter int HISTORY_DEPTH = csc_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS   = csc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [csc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_action,
   input  logic [SAMPLE_BITS-1:0]          req_sample,
   input  csc_pkg::csc_cmd_type            cmd,
   output csc_pkg::csc_status_type         status,
   output logic [csc_pkg::POS_W-1:0]       rsp_position,
   output logic [csc_pkg::DIR_W-1:0]       rsp_direction,
   output logic [csc_pkg::STEP_W-1:0]      rsp_step,
   output logic [csc_pkg::LEVEL_W-1:0]     rsp_centre_now
);

   localparam int CTR_W    = (SAMPLE_BITS > csc_pkg::LEVEL_W) ? SAMPLE_BITS : csc_pkg::LEVEL_W;
   localparam int DIV_W    = CTR_W + csc_pkg::SCALE_W;
   localparam int IDX_W    = $clog2(HISTORY_DEPTH);
   localparam int RANK_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int DCNT_W   = $clog2(DIV_W);
   localparam int MED_RANK = HISTORY_DEPTH / 2;
   localparam int PROD_W   = csc_pkg::POS_W + csc_pkg::STEP_RECIP_W;

   // settings
   logic [csc_pkg::LEVEL_W-1:0]  low_level_ff, low_level_in;
   logic [csc_pkg::LEVEL_W-1:0]  high_level_ff, high_level_in;
   logic [csc_pkg::MARGIN_W-1:0] dead_margin_ff, dead_margin_in;

   // calibration state
   logic [CTR_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [CTR_W-1:0] hist_in [HISTORY_DEPTH];
   logic [CTR_W-1:0] centre_ff, centre_in;
   logic             calibrated_ff, calibrated_in;

   // working registers
   logic [CTR_W-1:0]            sample_ff, sample_in;
   logic [IDX_W-1:0]            med_idx_ff, med_idx_in;
   logic                        upper_ff, upper_in;
   logic [CTR_W-1:0]            span_ff, span_in;
   logic [CTR_W-1:0]            rem_ff, rem_in;
   logic [DIV_W-1:0]            quo_ff, quo_in;
   logic [DCNT_W-1:0]           div_cnt_ff, div_cnt_in;
   logic [csc_pkg::POS_W-1:0]   pos_ff, pos_in;

   // result registers
   logic [csc_pkg::POS_W-1:0]   position_ff, position_in;
   logic [csc_pkg::DIR_W-1:0]   direction_ff, direction_in;
   logic [csc_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [csc_pkg::LEVEL_W-1:0] centre_now_ff, centre_now_in;

   // median rank scan
   logic [CTR_W-1:0]          med_val;
   logic [HISTORY_DEPTH-1:0]  lt_vec;
   logic [HISTORY_DEPTH-1:0]  eq_vec;
   logic [RANK_W-1:0]         rank;

   // map setup
   logic [CTR_W:0]            mid_x, s_x, m_x, hi_x, lo_x;
   logic [CTR_W:0]            mid_pm, s_pm, lo_pm, up_span_x, lo_span_x;
   logic                      is_upper, is_lower, up_ok, lo_ok, bypass;
   logic [CTR_W-1:0]          diff;
   logic [DIV_W-1:0]          dividend;
   logic [csc_pkg::POS_W-1:0] bypass_pos;

   // divider and position
   logic [CTR_W:0]            rem_sh;
   logic [CTR_W:0]            rem_sub;
   logic                      quo_bit;
   logic                      sat;
   logic [csc_pkg::POS_W-1:0] q_lo;

   // coarse step
   logic [csc_pkg::POS_W-1:0]  pos_delta;
   logic [PROD_W-1:0]          prod;
   logic [csc_pkg::STEP_W-1:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_level_ff   <= csc_pkg::LOW_LEVEL_RESET;
         high_level_ff  <= csc_pkg::HIGH_LEVEL_RESET;
         dead_margin_ff <= csc_pkg::DEAD_MARGIN_RESET;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= CTR_W'(csc_pkg::CENTRE_RESET);
         end
         centre_ff     <= CTR_W'(csc_pkg::CENTRE_RESET);
         calibrated_ff <= 1'b0;
         med_idx_ff    <= '0;
         div_cnt_ff    <= '0;
      end else begin
         low_level_ff   <= low_level_in;
         high_level_ff  <= high_level_in;
         dead_margin_ff <= dead_margin_in;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
         centre_ff     <= centre_in;
         calibrated_ff <= calibrated_in;
         med_idx_ff    <= med_idx_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      upper_ff      <= upper_in;
      span_ff       <= span_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      pos_ff        <= pos_in;
      position_ff   <= position_in;
      direction_ff  <= direction_in;
      step_ff       <= step_in;
      centre_now_ff <= centre_now_in;
   end

   // rank of the scanned entry in a stable sort of the history
   always_comb begin
      med_val = hist_ff[med_idx_ff];
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
         lt_vec[j] = hist_ff[j] < med_val;
         eq_vec[j] = (IDX_W'(j) < med_idx_ff) && (hist_ff[j] == med_val);
      end
      rank = RANK_W'($countones(lt_vec)) + RANK_W'($countones(eq_vec));
   end

   // side of the dead band, span and scaled distance
   always_comb begin
      mid_x     = {1'b0, centre_ff};
      s_x       = {1'b0, sample_ff};
      m_x       = (CTR_W + 1)'(dead_margin_ff);
      hi_x      = (CTR_W + 1)'(high_level_ff);
      lo_x      = (CTR_W + 1)'(low_level_ff);
      mid_pm    = mid_x + m_x;
      s_pm      = s_x + m_x;
      lo_pm     = lo_x + m_x;
      is_upper  = s_x > mid_pm;
      is_lower  = s_pm < mid_x;
      up_ok     = hi_x > mid_pm;
      lo_ok     = mid_x > lo_pm;
      up_span_x = hi_x - mid_pm;
      lo_span_x = mid_x - lo_pm;
      diff      = is_upper ? (sample_ff - centre_ff) : (centre_ff - sample_ff);
      dividend  = DIV_W'(diff) * DIV_W'(csc_pkg::POS_CENTRE);
      bypass    = !((is_upper && up_ok) || (is_lower && lo_ok));
      if (is_upper) begin
         bypass_pos = csc_pkg::POS_FULL;
      end else if (is_lower) begin
         bypass_pos = csc_pkg::POS_ZERO;
      end else begin
         bypass_pos = csc_pkg::POS_CENTRE;
      end
   end

   // one restoring divide step, position and coarse step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      quo_bit = rem_sh >= {1'b0, span_ff};
      rem_sub = quo_bit ? (rem_sh - {1'b0, span_ff}) : rem_sh;
      sat     = quo_ff >= DIV_W'(csc_pkg::POS_CENTRE);
      q_lo    = quo_ff[csc_pkg::POS_W-1:0];
      if (pos_ff >= csc_pkg::POS_CENTRE) begin
         pos_delta = pos_ff - csc_pkg::POS_CENTRE;
      end else begin
         pos_delta = csc_pkg::POS_CENTRE - pos_ff;
      end
      prod = PROD_W'(pos_delta) * PROD_W'(csc_pkg::STEP_RECIP);
      mag  = prod[csc_pkg::STEP_SHIFT +: csc_pkg::STEP_W];
   end

   always_comb begin
      low_level_in   = low_level_ff;
      high_level_in  = high_level_ff;
      dead_margin_in = dead_margin_ff;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      centre_in     = centre_ff;
      calibrated_in = calibrated_ff;
      sample_in     = sample_ff;
      med_idx_in    = med_idx_ff;
      upper_in      = upper_ff;
      span_in       = span_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      pos_in        = pos_ff;
      position_in   = position_ff;
      direction_in  = direction_ff;
      step_in       = step_ff;
      centre_now_in = centre_now_ff;

      if (csr_write_en) begin
         case (csr_index)
            csc_pkg::CSR_LOW_LEVEL:   low_level_in   = csr_wdata[csc_pkg::LEVEL_W-1:0];
            csc_pkg::CSR_HIGH_LEVEL:  high_level_in  = csr_wdata[csc_pkg::LEVEL_W-1:0];
            csc_pkg::CSR_DEAD_MARGIN: dead_margin_in = csr_wdata[csc_pkg::MARGIN_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         sample_in  = CTR_W'(req_sample);
         med_idx_in = '0;
         // shift the new sample into the history
         if (status.cal_req) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
               hist_in[i] = hist_ff[i + 1];
            end
            hist_in[HISTORY_DEPTH-1] = CTR_W'(req_sample);
            calibrated_in            = 1'b1;
         end
      end

      if (cmd.med_step) begin
         if (rank == RANK_W'(MED_RANK)) begin
            centre_in = med_val;
         end
         med_idx_in = med_idx_ff + IDX_W'(1);
      end

      if (cmd.setup) begin
         upper_in   = is_upper;
         span_in    = is_upper ? up_span_x[CTR_W-1:0] : lo_span_x[CTR_W-1:0];
         quo_in     = dividend;
         rem_in     = '0;
         div_cnt_in = '0;
         if (bypass) begin
            pos_in = bypass_pos;
         end
      end

      if (cmd.div_step) begin
         rem_in     = rem_sub[CTR_W-1:0];
         quo_in     = {quo_ff[DIV_W-2:0], quo_bit};
         div_cnt_in = div_cnt_ff + DCNT_W'(1);
      end

      if (cmd.position) begin
         // clamp on the quotient before the add or subtract
         if (upper_ff) begin
            pos_in = sat ? csc_pkg::POS_FULL : (csc_pkg::POS_CENTRE + q_lo);
         end else begin
            pos_in = sat ? csc_pkg::POS_ZERO : (csc_pkg::POS_CENTRE - q_lo);
         end
      end

      if (cmd.load_out) begin
         position_in   = pos_ff;
         step_in       = mag;
         centre_now_in = centre_ff[csc_pkg::LEVEL_W-1:0];
         if (mag == '0) begin
            direction_in = csc_pkg::DIR_CENTRED;
         end else if (pos_ff > csc_pkg::POS_CENTRE) begin
            direction_in = csc_pkg::DIR_POSITIVE;
         end else begin
            direction_in = csc_pkg::DIR_NEGATIVE;
         end
      end
   end

   assign status.cal_req  = req_action || !calibrated_ff;
   assign status.med_done = med_idx_ff == IDX_W'(HISTORY_DEPTH - 1);
   assign status.bypass   = bypass;
   assign status.div_done = div_cnt_ff == DCNT_W'(DIV_W - 1);

   assign rsp_position   = position_ff;
   assign rsp_direction  = direction_ff;
   assign rsp_step       = step_ff;
   assign rsp_centre_now = centre_now_ff;

endmodule
`default_nettype wire

// ----- dv/centred_stick_conditioner_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centred stick conditioner testbench
// Drives stick samples with read and calibrate actions over several register
// settings and idle patterns. A scoreboard tracks the median history and the
// midpoint, predicts position, direction, step and midpoint for every beat,
// and checks the result beats in order.
// ----------------------------------------------------------------------------
module centred_stick_conditioner_top_test;

   localparam int DEPTH          = csc_pkg::HISTORY_DEPTH_DEFAULT;
   localparam int SBITS          = csc_pkg::SAMPLE_BITS_DEFAULT;
   localparam int SAMPLE_MAX     = (1 << SBITS) - 1;
   localparam int CENTRE_POS     = 500;
   localparam int FULL_POS       = 1000;
   localparam int STEP_SIZE      = 50;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 225;

   typedef struct packed {
      logic [csc_pkg::POS_W-1:0]   position;
      logic [csc_pkg::DIR_W-1:0]   direction;
      logic [csc_pkg::STEP_W-1:0]  step;
      logic [csc_pkg::LEVEL_W-1:0] centre_now;
   } stick_result_type;

   class stick_scoreboard;
      int               history[DEPTH];
      int               centre;
      bit               calibrated;
      int               low_lvl;
      int               high_lvl;
      int               margin;
      stick_result_type expected_q[$];
      int               errors;
      int               checked;
      int               noted;
      int               calibrations;

      function new();
         foreach (history[i]) history[i] = csc_pkg::CENTRE_RESET;
         centre       = csc_pkg::CENTRE_RESET;
         calibrated   = 1'b0;
         low_lvl      = csc_pkg::LOW_LEVEL_RESET;
         high_lvl     = csc_pkg::HIGH_LEVEL_RESET;
         margin       = csc_pkg::DEAD_MARGIN_RESET;
         errors       = 0;
         checked      = 0;
         noted        = 0;
         calibrations = 0;
      endfunction

      function void set_register(logic [csc_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [csc_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            csc_pkg::CSR_LOW_LEVEL:   low_lvl  = data[csc_pkg::LEVEL_W-1:0];
            csc_pkg::CSR_HIGH_LEVEL:  high_lvl = data[csc_pkg::LEVEL_W-1:0];
            csc_pkg::CSR_DEAD_MARGIN: margin   = data[csc_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      endfunction

      // shift the sample into the history and take the median as midpoint
      function void recalibrate(int s);
         int sorted[DEPTH];
         int j;
         int v;
         for (int i = 0; i < DEPTH - 1; i++) history[i] = history[i + 1];
         history[DEPTH - 1] = s;
         for (int i = 0; i < DEPTH; i++) begin
            v = history[i];
            j = i;
            while (j > 0 && sorted[j - 1] > v) begin
               sorted[j] = sorted[j - 1];
               j--;
            end
            sorted[j] = v;
         end
         centre     = sorted[DEPTH / 2];
         calibrated = 1'b1;
         calibrations++;
      endfunction

      function int map_position(int s);
         int span;
         int pos;
         if (s > centre + margin) begin
            // distance keeps the margin, span drops it
            span = high_lvl - centre - margin;
            if (span <= 0)
               pos = FULL_POS;
            else
               pos = CENTRE_POS + (CENTRE_POS * (s - centre)) / span;
         end else if (s < centre - margin) begin
            span = centre - low_lvl - margin;
            if (span <= 0)
               pos = 0;
            else
               pos = CENTRE_POS - (CENTRE_POS * (centre - s)) / span;
         end else begin
            pos = CENTRE_POS;
         end
         if (pos < 0) pos = 0;
         if (pos > FULL_POS) pos = FULL_POS;
         return pos;
      endfunction

      function void note_input(bit act, int s);
         stick_result_type r;
         int               pos;
         int               coarse;
         if (act || !calibrated) recalibrate(s);
         pos    = map_position(s);
         coarse = (pos - CENTRE_POS) / STEP_SIZE;
         r.position   = pos[csc_pkg::POS_W-1:0];
         r.centre_now = centre[csc_pkg::LEVEL_W-1:0];
         if (coarse > 0) begin
            r.direction = csc_pkg::DIR_POSITIVE;
            r.step      = coarse[csc_pkg::STEP_W-1:0];
         end else if (coarse < 0) begin
            r.direction = csc_pkg::DIR_NEGATIVE;
            r.step      = csc_pkg::STEP_W'(-coarse);
         end else begin
            r.direction = csc_pkg::DIR_CENTRED;
            r.step      = '0;
         end
         expected_q.push_back(r);
         noted++;
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [csc_pkg::POS_W-1:0] p, logic [csc_pkg::DIR_W-1:0] d,
                                 logic [csc_pkg::STEP_W-1:0] st,
                                 logic [csc_pkg::LEVEL_W-1:0] c);
         stick_result_type want;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: expected none, actual position %0d centre %0d",
                     $time, p, c);
            return;
         end
         want = expected_q.pop_front();
         if ($isunknown({p, d, st, c})) begin
            errors++;
            $display("%0t: unknown bits in result: expected %h, actual %h", $time, want,
                     {p, d, st, c});
            return;
         end
         compare_field("position", want.position, p);
         compare_field("direction", want.direction, d);
         compare_field("step", want.step, st);
         compare_field("centre_now", want.centre_now, c);
      endfunction
   endclass

   logic                              clock          = 1'b0;
   logic                              reset          = 1'b1;
   logic                              csr_write_en   = 1'b0;
   logic [csc_pkg::CSR_INDEX_W-1:0]   csr_index      = csc_pkg::CSR_LOW_LEVEL;
   logic [csc_pkg::CSR_DATA_W-1:0]    csr_wdata      = '0;
   logic                              req_valid      = 1'b0;
   logic                              req_ready;
   logic                              req_action     = 1'b0;
   logic [SBITS-1:0]                  req_sample     = '0;
   logic                              rsp_valid;
   logic                              rsp_ready      = 1'b0;
   logic [csc_pkg::POS_W-1:0]         rsp_position;
   logic [csc_pkg::DIR_W-1:0]         rsp_direction;
   logic [csc_pkg::STEP_W-1:0]        rsp_step;
   logic [csc_pkg::LEVEL_W-1:0]       rsp_centre_now;

   stick_scoreboard sb;
   int              sender_idle_pct   = 0;
   int              receiver_idle_pct = 0;
   int              quiet_cycles      = 0;

   centred_stick_conditioner_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position   (rsp_position),
      .rsp_direction  (rsp_direction),
      .rsp_step       (rsp_step),
      .rsp_centre_now (rsp_centre_now)
   );

   always #5 clock = ~clock;

   // result side: check accepted beats, stall at random, watch for a hang
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_position, rsp_direction, rsp_step, rsp_centre_now);
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no beat for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, sb.expected_q.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(bit act, int s, bit hold);
      if (hold || $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
         // hold off until the block has returned everything
         if (hold)
            while (sb.expected_q.size() != 0) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_sample <= s[SBITS-1:0];
      do @(posedge clock); while (!req_ready);
      sb.note_input(act, s);
   endtask

   task automatic settle();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(int lo, int hi, int dm);
      csr_write_en <= 1'b1;
      csr_index    <= csc_pkg::CSR_LOW_LEVEL;
      csr_wdata    <= lo[csc_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index    <= csc_pkg::CSR_HIGH_LEVEL;
      csr_wdata    <= hi[csc_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index    <= csc_pkg::CSR_DEAD_MARGIN;
      csr_wdata    <= dm[csc_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_register(csc_pkg::CSR_LOW_LEVEL, lo[csc_pkg::CSR_DATA_W-1:0]);
      sb.set_register(csc_pkg::CSR_HIGH_LEVEL, hi[csc_pkg::CSR_DATA_W-1:0]);
      sb.set_register(csc_pkg::CSR_DEAD_MARGIN, dm[csc_pkg::CSR_DATA_W-1:0]);
      repeat (2) @(posedge clock);
   endtask

   function automatic int pick_sample(bit act);
      int r;
      int v;
      r = $urandom_range(99);
      if (act) begin
         // mostly near mid scale so the midpoint wanders but stays useful
         if (r < 70)
            v = 512 + int'($urandom_range(300)) - 150;
         else
            v = $urandom_range(SAMPLE_MAX);
      end else if (r < 30) begin
         v = $urandom_range(SAMPLE_MAX);
      end else if (r < 60) begin
         v = sb.centre + int'($urandom_range(2 * sb.margin + 8)) - sb.margin - 4;
      end else if (r < 70) begin
         v = $urandom_range(1) ? SAMPLE_MAX : 0;
      end else if (r < 85) begin
         v = sb.low_lvl + int'($urandom_range(20)) - 10;
      end else begin
         v = sb.high_lvl + int'($urandom_range(20)) - 10;
      end
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return v;
   endfunction

   initial begin
      int lo;
      int hi;
      int dm;
      bit act;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: first read calibrates, band edges, ends of scale,
      // midpoint pulled to either end so the band crosses zero or the top
      send_item(1'b0, 512, 1'b0);
      send_item(1'b0, 0, 1'b0);
      send_item(1'b0, SAMPLE_MAX, 1'b0);
      send_item(1'b0, 520, 1'b0);
      send_item(1'b0, 521, 1'b0);
      send_item(1'b0, 504, 1'b0);
      send_item(1'b0, 503, 1'b0);
      repeat (5) send_item(1'b1, 5, 1'b0);
      send_item(1'b0, 0, 1'b0);
      send_item(1'b0, SAMPLE_MAX, 1'b0);
      send_item(1'b0, 10'h2AA, 1'b0);
      repeat (5) send_item(1'b1, SAMPLE_MAX, 1'b0);
      send_item(1'b0, 1020, 1'b0);
      send_item(1'b0, 0, 1'b0);
      send_item(1'b1, 10'h155, 1'b0);
      send_item(1'b0, 10'h155, 1'b0);
      req_valid <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         case (phase)
            0: begin lo = 0; hi = SAMPLE_MAX; dm = 0; end
            1: begin lo = 0; hi = SAMPLE_MAX; dm = 10'h3FF; end
            // spans can only be zero or negative here
            2: begin lo = SAMPLE_MAX; hi = 0; dm = $urandom_range(255); end
            3: begin
               lo = $urandom_range(200);
               hi = SAMPLE_MAX - int'($urandom_range(200));
               dm = $urandom_range(40);
            end
            4: begin lo = 512; hi = 512; dm = $urandom_range(16); end
            5: begin
               lo = $urandom_range(SAMPLE_MAX);
               hi = $urandom_range(SAMPLE_MAX);
               dm = $urandom_range(255);
            end
            6: begin lo = 100; hi = 900; dm = 8; end
            default: begin
               lo = $urandom_range(300);
               hi = 700 + int'($urandom_range(323));
               dm = $urandom_range(20);
            end
         endcase
         write_settings(lo, hi, dm);
         sender_idle_pct   = (phase % 4 == 1) ? 56 : (phase % 4 == 3) ? 19 : 0;
         receiver_idle_pct = (phase % 4 == 2) ? 56 : (phase % 4 == 3) ? 19 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            act = ($urandom_range(99) < 30);
            send_item(act, pick_sample(act), n == PHASE_ITEMS / 2);
         end
         req_valid <= 1'b0;
      end

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d stick samples (%0d calibrations) over %0d register settings,",
               sb.noted, sb.calibrations, PHASE_COUNT + 1);
      $display("with free-running, sender-idle, receiver-stall and mixed traffic; %0d checked.",
               sb.checked);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
